>>> sv/ansi_escape_stripper_unit_defines.svh
// ----------------------------------------------------------------------------
// ANSI escape stripper assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ANSI_ESCAPE_STRIPPER_UNIT_DEFINES_SVH
`define ANSI_ESCAPE_STRIPPER_UNIT_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define AES_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define AES_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/aes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI escape stripper package
// Widths, character codes, parser modes and the control/status bundles.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int CHAR_W     = 21;
  localparam int CNT_W      = 16;
  localparam int HOLD_DEPTH = 32;
  localparam int LEN_W      = $clog2(HOLD_DEPTH + 1);
  localparam int IDX_W      = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  localparam logic [CHAR_W-1:0] C_BEL      = CHAR_W'('h07);
  localparam logic [CHAR_W-1:0] C_TAB      = CHAR_W'('h09);
  localparam logic [CHAR_W-1:0] C_LF       = CHAR_W'('h0A);
  localparam logic [CHAR_W-1:0] C_ESC      = CHAR_W'('h1B);
  localparam logic [CHAR_W-1:0] C_SPACE    = CHAR_W'('h20);
  localparam logic [CHAR_W-1:0] C_FINAL_LO = CHAR_W'('h40);
  localparam logic [CHAR_W-1:0] C_DCS      = CHAR_W'('h50);
  localparam logic [CHAR_W-1:0] C_SOS      = CHAR_W'('h58);
  localparam logic [CHAR_W-1:0] C_CSI      = CHAR_W'('h5B);
  localparam logic [CHAR_W-1:0] C_BSLASH   = CHAR_W'('h5C);
  localparam logic [CHAR_W-1:0] C_OSC      = CHAR_W'('h5D);
  localparam logic [CHAR_W-1:0] C_PM       = CHAR_W'('h5E);
  localparam logic [CHAR_W-1:0] C_APC      = CHAR_W'('h5F);
  localparam logic [CHAR_W-1:0] C_FINAL_HI = CHAR_W'('h7E);
  localparam logic [CHAR_W-1:0] C_DEL      = CHAR_W'('h7F);

  // Escape parser mode
  typedef enum logic [6:0] {
    MODE_TEXT    = 7'b0000001,
    MODE_ESC     = 7'b0000010,
    MODE_CSI     = 7'b0000100,
    MODE_OSC     = 7'b0001000,
    MODE_OSC_ESC = 7'b0010000,
    MODE_STR     = 7'b0100000,
    MODE_STR_ESC = 7'b1000000
  } mode_t;

  // What the current character does in text mode
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_HOLD  = 2'd1,
    KIND_PRINT = 2'd2
  } kind_t;

  // Source of an output request
  typedef enum logic [1:0] {
    SRC_HEAD     = 2'd0,
    SRC_HEAD_OVF = 2'd1,
    SRC_CHAR     = 2'd2,
    SRC_MARK     = 2'd3
  } src_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic pop;
    logic emit;
    src_t src;
    logic last;
    logic clear;
    logic done;
  } aes_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  run_full;
    logic  run_empty;
    logic  item_last;
    logic  put_ok;
    logic  limit_next;
    logic  emitted_any;
    logic  out_free;
  } aes_stat_t;

endpackage

>>> sv/aes_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI escape stripper controller
// Sequences each request: evaluate, flush held run, emit, end marker.
// ----------------------------------------------------------------------------
`include "ansi_escape_stripper_unit_defines.svh"

module aes_ctrl import aes_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  aes_stat_t stat,
  output aes_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic put;
  src_t put_src;
  logic fin;
  logic to_flush;
  logic busy;
  logic emit_put;
  logic mark;
  logic emit;
  logic go;

  // Decide what the current step wants to output
  always_comb begin
    put      = 1'b0;
    put_src  = SRC_CHAR;
    fin      = 1'b0;
    to_flush = 1'b0;
    busy     = 1'b0;
    case (state)
      S_EVAL: begin
        busy = 1'b1;
        case (stat.kind)
          KIND_HOLD: begin
            put     = stat.run_full;
            put_src = SRC_HEAD_OVF;
            fin     = 1'b1;
          end
          KIND_PRINT: begin
            if (stat.run_empty) begin
              put = 1'b1;
              fin = 1'b1;
            end else begin
              to_flush = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_FLUSH: begin
        busy = 1'b1;
        put  = 1'b1;
        if (!stat.run_empty) begin
          put_src = SRC_HEAD;
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  assign emit_put = put && stat.put_ok;
  assign mark     = fin && stat.item_last && !stat.emitted_any && !emit_put;
  assign emit     = emit_put || mark;
  assign go       = busy && (!emit || stat.out_free);

  // Issue commands and advance
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    if (state == S_IDLE) begin
      in_stall = 1'b0;
      if (in_valid) begin
        cmd.load   = 1'b1;
        state_next = S_EVAL;
      end
    end else if (go) begin
      cmd.emit = emit;
      cmd.src  = mark ? SRC_MARK : put_src;
      cmd.last = mark || (stat.item_last && (fin || stat.limit_next));
      cmd.eval = (state == S_EVAL);
      cmd.pop  = (state == S_FLUSH) && !stat.run_empty;
      if (fin) begin
        cmd.done  = 1'b1;
        cmd.clear = stat.item_last;
        in_stall  = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end else begin
          state_next = S_IDLE;
        end
      end else if (to_flush) begin
        state_next = S_FLUSH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `AES_ASSERT_IMP(a_flush_print, state == S_FLUSH, stat.kind == KIND_PRINT, "flush without printable char")

endmodule

>>> sv/aes_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI escape stripper datapath
// Request register, escape parser, held run queue, limit counter, output reg.
// ----------------------------------------------------------------------------
`include "ansi_escape_stripper_unit_defines.svh"

module aes_dpath import aes_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_last,
  input  logic              res_stall,
  input  aes_cmd_t          cmd,
  output aes_stat_t         stat,
  output logic              res_valid,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_valid,
  output logic              out_last,
  output logic              out_overflow
);

  logic [CHAR_W-1:0]     item_char;
  logic                  item_last;
  mode_t                 mode;
  mode_t                 mode_next;
  kind_t                 kind;
  logic [LEN_W-1:0]      run_len;
  logic [HOLD_DEPTH-1:0] run_kinds;
  logic [CNT_W-1:0]      emit_count;
  logic [CNT_W-1:0]      max_chars;
  logic                  emitted_any;
  logic                  run_full;
  logic                  is_lf;
  logic [CHAR_W-1:0]     head_char;
  logic [CHAR_W-1:0]     sel_char;

  assign is_lf     = (item_char == C_LF);
  assign run_full  = (run_len == LEN_W'(HOLD_DEPTH));
  assign head_char = run_kinds[0] ? C_LF : C_SPACE;

  // Escape parser: next mode and text-mode classification
  always_comb begin
    mode_next = mode;
    kind      = KIND_NONE;
    case (mode)
      MODE_ESC: begin
        if (item_char == C_CSI) begin
          mode_next = MODE_CSI;
        end else if (item_char == C_OSC) begin
          mode_next = MODE_OSC;
        end else if (item_char == C_DCS || item_char == C_SOS ||
                     item_char == C_PM || item_char == C_APC) begin
          mode_next = MODE_STR;
        end else begin
          mode_next = MODE_TEXT;
        end
      end
      MODE_CSI: begin
        if (item_char >= C_FINAL_LO && item_char <= C_FINAL_HI) begin
          mode_next = MODE_TEXT;
        end
      end
      MODE_OSC: begin
        if (item_char == C_BEL) begin
          mode_next = MODE_TEXT;
        end else if (item_char == C_ESC) begin
          mode_next = MODE_OSC_ESC;
        end
      end
      MODE_OSC_ESC: begin
        if (item_char == C_BSLASH || item_char == C_BEL) begin
          mode_next = MODE_TEXT;
        end else if (item_char != C_ESC) begin
          mode_next = MODE_OSC;
        end
      end
      MODE_STR: begin
        if (item_char == C_ESC) begin
          mode_next = MODE_STR_ESC;
        end
      end
      MODE_STR_ESC: begin
        if (item_char == C_BSLASH) begin
          mode_next = MODE_TEXT;
        end else if (item_char != C_ESC) begin
          mode_next = MODE_STR;
        end
      end
      default: begin
        mode_next = (item_char == C_ESC) ? MODE_ESC : MODE_TEXT;
        if (item_char == C_LF || item_char == C_SPACE) begin
          kind = KIND_HOLD;
        end else if (item_char == C_TAB ||
                     (item_char > C_SPACE && item_char != C_DEL)) begin
          kind = KIND_PRINT;
        end
      end
    endcase
  end

  always_comb begin
    stat.kind        = kind;
    stat.run_full    = run_full;
    stat.run_empty   = (run_len == '0);
    stat.item_last   = item_last;
    stat.put_ok      = (max_chars == '0) || (emit_count < max_chars);
    stat.limit_next  = (max_chars != '0) &&
                       (({1'b0, emit_count} + (CNT_W+1)'(1)) >= {1'b0, max_chars});
    stat.emitted_any = emitted_any;
    stat.out_free    = !res_valid || !res_stall;
  end

  always_comb begin
    case (cmd.src)
      SRC_HEAD:     sel_char = head_char;
      SRC_HEAD_OVF: sel_char = head_char;
      SRC_CHAR:     sel_char = item_char;
      default:      sel_char = '0;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_TEXT;
      run_len     <= '0;
      emit_count  <= '0;
      max_chars   <= '0;
      emitted_any <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_chars <= cfg_wdata;
      end
      if (cmd.eval) begin
        mode <= mode_next;
      end
      if (cmd.eval && kind == KIND_HOLD && !run_full) begin
        run_len <= run_len + LEN_W'(1);
      end else if (cmd.pop) begin
        run_len <= run_len - LEN_W'(1);
      end
      if (cmd.emit && cmd.src != SRC_MARK && emit_count != '1) begin
        emit_count <= emit_count + CNT_W'(1);
      end
      if (cmd.done) begin
        emitted_any <= 1'b0;
      end else if (cmd.emit) begin
        emitted_any <= 1'b1;
      end
      // end of text: drop everything held
      if (cmd.clear) begin
        mode       <= MODE_TEXT;
        run_len    <= '0;
        emit_count <= '0;
      end
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload: request register, run queue, output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_char <= in_char;
      item_last <= in_last;
    end
    if (cmd.eval && kind == KIND_HOLD) begin
      if (run_full) begin
        // drop the oldest entry and append the new one at the top
        run_kinds <= {is_lf, run_kinds[HOLD_DEPTH-1:1]};
      end else begin
        run_kinds[run_len[IDX_W-1:0]] <= is_lf;
      end
    end else if (cmd.pop) begin
      run_kinds <= run_kinds >> 1;
    end
    if (cmd.emit) begin
      out_char     <= sel_char;
      out_valid    <= (cmd.src != SRC_MARK);
      out_last     <= cmd.last;
      out_overflow <= (cmd.src == SRC_HEAD_OVF);
    end
  end

  `AES_ASSERT_IMP(a_len_bound, 1'b1, run_len <= LEN_W'(HOLD_DEPTH), "run length past depth")
  `AES_ASSERT_IMP(a_ovf_full, cmd.emit && cmd.src == SRC_HEAD_OVF, run_full, "overflow not full")
  `AES_ASSERT_IMP(a_emit_free, cmd.emit, !(res_valid && res_stall), "output overwritten")
  `AES_ASSERT_NXT(a_clear, cmd.clear, run_len == '0 && emit_count == '0 && mode == MODE_TEXT, "clear failed")

endmodule

>>> sv/ansi_escape_stripper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI escape stripper unit
// Cleans a code point stream of terminal control sequences and control chars.
// ----------------------------------------------------------------------------
// Takes one code point per request and produces clean text: CSI, OSC,
// DCS/SOS/PM/APC and two-character escapes are dropped, as are CR, DEL and
// the other C0 control characters; LF and TAB pass. A run of LF/space is held
// (up to 32 entries) and flushed just before the next kept character, or
// dropped when the text ends; a run longer than that emits its oldest entry
// early with out_overflow set. max_chars (0 = unlimited) caps characters per
// text. The final request of a text always yields a result with out_last set;
// a bare end marker (out_valid 0) appears when it produces no character.
// Timing: text that is dropped, held or printed with no held run flows one
// code point per cycle while the output is not stalled. A printable character
// behind a held run waits, input stalled, while the controller walks the run
// queue one entry per cycle through the single output register. A
// stalled output holds a request in place once it needs to emit. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------

module ansi_escape_stripper_unit import aes_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration: max_chars
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  // input requests
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_last,
  // result requests
  output logic              res_valid,
  input  logic              res_stall,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_valid,
  output logic              out_last,
  output logic              out_overflow
);

  aes_cmd_t  cmd;
  aes_stat_t stat;

  // Controller: decides per step whether to emit, flush or advance
  aes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: parser, held run queue, limit counter and output register
  aes_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_char      (in_char),
    .in_last      (in_last),
    .res_stall    (res_stall),
    .cmd          (cmd),
    .stat         (stat),
    .res_valid    (res_valid),
    .out_char     (out_char),
    .out_valid    (out_valid),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

endmodule
